// ----- design/ipv_pkg.sv -----
package ipv_pkg;

  localparam int MAX_COUNT_DEF = 64;
  localparam int SAMPLE_W      = 16;
  localparam int VAR_W         = 32;
  localparam int COUNT_W       = 7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic [VAR_W-1:0]           variance;
    logic [COUNT_W-1:0]         count;
    logic                       overflow;
  } result_t;

endpackage

// ----- design/ipv_ram.sv -----
module ipv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ipv_div.sv -----
module ipv_div #(
  parameter int DW = 38,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int NW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [NW-1:0] steps;
  logic          run;
  logic [VW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (go && !run) begin
        run   <= 1'b1;
        steps <= NW'(DW);
      end else if (run) begin
        steps <= steps - 1'b1;
        if (steps == NW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !run) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (run) begin
      quotient <= {quotient[DW-2:0], fits};
      rem      <= fits ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
    end
  end

endmodule

// ----- design/ipv_sqacc.sv -----
module ipv_sqacc
  import ipv_pkg::*;
#(
  parameter int ACC_W = 38
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                rd_issue,
  input  logic [SAMPLE_W-1:0] rdata,
  input  logic [SAMPLE_W-1:0] mean,
  output logic                busy,
  output logic [ACC_W-1:0]    acc
);

  logic                  v0, v1, v2;
  logic [SAMPLE_W:0]     diff;
  logic [SAMPLE_W:0]     diff_abs;
  logic [SAMPLE_W-1:0]   dev;
  logic [2*SAMPLE_W-1:0] sq;

  // deviation needs one extra bit, its magnitude never exceeds 16 bits
  assign diff     = {rdata[SAMPLE_W-1], rdata} - {mean[SAMPLE_W-1], mean};
  assign diff_abs = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= rd_issue;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v0) begin
      dev <= diff_abs[SAMPLE_W-1:0];
    end
    if (v1) begin
      sq <= (2*SAMPLE_W)'(dev) * (2*SAMPLE_W)'(dev);
    end
    if (clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W-2*SAMPLE_W){1'b0}}, sq};
    end
  end

  assign busy = v0 | v1 | v2;

endmodule

// ----- design/integer_population_variance_unit.sv -----
// Population variance of a set of signed 16-bit samples. Samples are taken one
// per cycle while busy is low; the sample with last set closes the set. Samples
// past MAX_COUNT are dropped and reported through overflow. After the closing
// sample busy stays high through two passes of a one-bit-a-cycle divider
// (mean, then variance) and one read pass over the sample memory through the
// squaring pipeline. The result shows for a single cycle with done high and
// cannot be held off; take it then or lose it.
module integer_population_variance_unit
  import ipv_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int AW = $clog2(MAX_COUNT);
  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int SW = SAMPLE_W + AW;
  localparam int DW = VAR_W + AW;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_MSTART = 3'd1;
  localparam logic [2:0] ST_MEAN   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_VAR    = 3'd5;

  logic [2:0]           state;
  logic signed [SW-1:0] sum;
  logic [CW-1:0]        count;
  logic                 dropped;
  logic [CW-1:0]        scan;
  logic [SAMPLE_W-1:0]  mean;

  logic                 accept;
  logic                 room;
  logic [SW-1:0]        sample_ext;
  logic [SW-1:0]        sum_mag;
  logic [SAMPLE_W-1:0]  mean_mag;
  logic                 rd_issue;
  logic [SAMPLE_W-1:0]  rdata;
  logic                 sq_busy;
  logic [DW-1:0]        acc;
  logic                 div_go;
  logic [DW-1:0]        div_dividend;
  logic                 div_done;
  logic [DW-1:0]        div_q;
  logic [CW+COUNT_W-1:0] count_ext;

  assign busy       = state != ST_LOAD;
  assign accept     = start && !busy;
  assign room       = count < CW'(MAX_COUNT);
  assign sample_ext = {{(SW-SAMPLE_W){item.sample[SAMPLE_W-1]}}, item.sample};
  assign sum_mag    = sum[SW-1] ? (~sum + 1'b1) : sum;
  assign mean_mag   = div_q[SAMPLE_W-1:0];
  assign rd_issue   = state == ST_SCAN;
  assign count_ext  = {{COUNT_W{1'b0}}, count};

  assign div_go       = (state == ST_MSTART) || (state == ST_DRAIN && !sq_busy);
  assign div_dividend = (state == ST_MSTART) ? {{(DW-SW){1'b0}}, sum_mag} : acc;

  ipv_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (accept && room),
    .waddr (count[AW-1:0]),
    .wdata (item.sample),
    .raddr (scan[AW-1:0]),
    .rdata (rdata)
  );

  ipv_sqacc #(
    .ACC_W (DW)
  ) u_sqacc (
    .clk      (clk),
    .rst      (rst),
    .clear    (state == ST_MSTART),
    .rd_issue (rd_issue),
    .rdata    (rdata),
    .mean     (mean),
    .busy     (sq_busy),
    .acc      (acc)
  );

  ipv_div #(
    .DW (DW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      sum     <= '0;
      count   <= '0;
      dropped <= 1'b0;
      scan    <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              sum   <= sum + $signed(sample_ext);
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (item.last) begin
              state <= ST_MSTART;
            end
          end
        end
        ST_MSTART: begin
          state <= ST_MEAN;
        end
        ST_MEAN: begin
          if (div_done) begin
            scan  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan <= scan + 1'b1;
          if (scan + 1'b1 == count) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!sq_busy) begin
            state <= ST_VAR;
          end
        end
        ST_VAR: begin
          if (div_done) begin
            done    <= 1'b1;
            sum     <= '0;
            count   <= '0;
            dropped <= 1'b0;
            state   <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // truncated mean keeps the sign of the sum
  always_ff @(posedge clk) begin
    if (state == ST_MEAN && div_done) begin
      mean <= sum[SW-1] ? (~mean_mag + 1'b1) : mean_mag;
    end
    if (state == ST_VAR && div_done) begin
      result.mean     <= mean;
      result.variance <= div_q[VAR_W-1:0];
      result.count    <= count_ext[COUNT_W-1:0];
      result.overflow <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_COUNT))
    else $error("sample count beyond store depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && count == '0 && !dropped)
    else $error("set state not cleared with result");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    accept && item.last |=> busy)
    else $error("closing transaction did not start the computation");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan < count)
    else $error("store read beyond filled entries");

  a_done_from_var: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_VAR && $past(div_done))
    else $error("result strobe outside variance division");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ipv_pkg::*;

  localparam int DEPTH     = MAX_COUNT_DEF;
  localparam int N_ITEMS   = 1750;
  localparam int TAIL_CYC  = 300;

  typedef struct {
    item_t it;
    int    gap;
    bit    drain;
  } stim_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  stim_t   stim_q[$];
  result_t stats_due[$];
  int      mismatches = 0;
  int      queued = 0;
  bit      calm = 1'b0;

  // running copy of the set being loaded
  logic signed [SAMPLE_W-1:0] kept[DEPTH];
  longint                     set_sum = 0;
  int                         set_len = 0;
  bit                         set_dropped = 1'b0;

  int hold_left = 0;
  bit hold_armed = 1'b0;

  integer_population_variance_unit #(
    .MAX_COUNT(DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stores the sample and, on the closing one, works out mean and variance
  function automatic void absorb_sample(item_t it);
    longint  avg;
    longint  dev;
    longint  sq_sum;
    result_t r;
    if (set_len < DEPTH) begin
      kept[set_len] = it.sample;
      set_sum += it.sample;
      set_len++;
    end else begin
      set_dropped = 1'b1;
    end
    if (it.last) begin
      avg = set_sum / set_len;
      sq_sum = 0;
      for (int i = 0; i < set_len; i++) begin
        dev = longint'(kept[i]) - avg;
        sq_sum += dev * dev;
      end
      r.mean     = avg[SAMPLE_W-1:0];
      r.variance = 32'(sq_sum / set_len);
      r.count    = COUNT_W'(set_len);
      r.overflow = set_dropped;
      stats_due.push_back(r);
      set_sum = 0;
      set_len = 0;
      set_dropped = 1'b0;
    end
  endfunction

  function automatic void add_sample(int value, bit last, bit drain);
    stim_t s;
    s.it.sample = value[SAMPLE_W-1:0];
    s.it.last   = last;
    s.gap       = calm ? 0 : $urandom_range(0, 8);
    s.drain     = drain;
    stim_q.push_back(s);
    queued++;
  endfunction

  function automatic int draw_value(int mode, int base);
    int v;
    case (mode)
      0: v = $signed(16'($urandom));
      1: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: begin
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
    endcase
    return v;
  endfunction

  // driver: one transaction in flight, random hold-off before each
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item  <= '0;
      hold_left = 0;
      hold_armed = 1'b0;
    end else begin
      if (start && !busy) absorb_sample(item);
      if (!start || !busy) begin
        if (stim_q.size() != 0 && !hold_armed) begin
          hold_left = stim_q[0].gap;
          hold_armed = 1'b1;
        end
        if (stim_q.size() == 0 || hold_left != 0 ||
            (stim_q[0].drain && stats_due.size() != 0)) begin
          if (hold_left != 0) hold_left--;
          start <= 1'b0;
        end else begin
          item  <= stim_q[0].it;
          start <= 1'b1;
          void'(stim_q.pop_front());
          hold_armed = 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (stats_due.size() == 0) begin
        $error("unexpected result: mean %0d variance %0d count %0d overflow %0b",
               result.mean, result.variance, result.count, result.overflow);
        mismatches++;
      end else begin
        want = stats_due.pop_front();
        if (result.mean !== want.mean) begin
          $error("mean: expected %0d, got %0d", want.mean, result.mean);
          mismatches++;
        end
        if (result.variance !== want.variance) begin
          $error("variance: expected %0d, got %0d", want.variance, result.variance);
          mismatches++;
        end
        if (result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, result.count);
          mismatches++;
        end
        if (result.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int len;
    int mode;
    int base;
    int pick;
    // directed sets
    add_sample(32767, 1'b1, 1'b0);
    add_sample(-32768, 1'b1, 1'b0);
    add_sample(-1, 1'b0, 1'b0);
    add_sample(0, 1'b1, 1'b0);
    add_sample(-3, 1'b0, 1'b0);
    add_sample(-2, 1'b1, 1'b0);
    add_sample(-32768, 1'b0, 1'b1);
    add_sample(32767, 1'b1, 1'b0);
    add_sample(5, 1'b0, 1'b0);
    add_sample(5, 1'b0, 1'b0);
    add_sample(5, 1'b1, 1'b0);
    add_sample(-32768, 1'b0, 1'b1);
    add_sample(-32768, 1'b0, 1'b0);
    add_sample(32767, 1'b0, 1'b0);
    add_sample(32767, 1'b1, 1'b0);
    add_sample(7, 1'b0, 1'b0);
    add_sample(-8, 1'b0, 1'b0);
    add_sample(2, 1'b1, 1'b0);
    // random sets, mostly short, some filling or overrunning the store
    while (queued < N_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      len = $urandom_range(1, 4);
      else if (pick < 7) len = $urandom_range(5, 20);
      else if (pick < 9) len = $urandom_range(21, DEPTH);
      else               len = $urandom_range(DEPTH, DEPTH + 16);
      mode = $urandom_range(0, 2);
      base = $signed(16'($urandom));
      calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++)
        add_sample(draw_value(mode, base), i == len - 1,
                   i == 0 && $urandom_range(0, 19) == 0);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // checked away from the active edge so queue and start have settled
    while (stim_q.size() != 0 || start) @(negedge clk);
    while (stats_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ipv_pkg.sv
design/ipv_ram.sv
design/ipv_div.sv
design/ipv_sqacc.sv
design/integer_population_variance_unit.sv
bench/tb.sv
